// File: rtl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by the front end, the back end and the top level.
package lkv_pkg;

    // default sizes of the store
    localparam int CAPACITY_DEF   = 8;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // port field widths
    localparam int KEY_PORT_BITS   = 32;
    localparam int VALUE_PORT_BITS = 32;

    // queue depths between front, back and result side
    localparam int ITEM_Q_DEPTH = 2;
    localparam int RES_Q_DEPTH  = 4;

    // access codes on the op field
    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    // back end sequencer
    typedef enum logic
    {
        BK_MATCH,
        BK_EXEC
    } back_state_t;

    // one result item
    typedef struct packed
    {
        logic                       hit;
        logic [VALUE_PORT_BITS-1:0] read_value;
    } res_t;

endpackage

// File: rtl/lkv_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the value store.
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/lkv_fifo.sv
// Small first-in first-out queue with a fill count.
// No dependencies; used for the item queue and the result queue.
module lkv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [WIDTH-1:0]               din,
    output logic                           full,
    input  logic                           pop,
    output logic [WIDTH-1:0]               dout,
    output logic                           empty,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             push_ok, pop_ok;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: rtl/lkv_front.sv
// Front end: takes items in, classifies the access and sizes key and value.
// Depends on lkv_pkg and lkv_fifo.
module lkv_front #(
    parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                op,
    input  logic [lkv_pkg::KEY_PORT_BITS-1:0]   lookup_key,
    input  logic [lkv_pkg::VALUE_PORT_BITS-1:0] write_value,
    input  logic                                item_pop,
    output logic                                item_empty,
    output logic                                item_is_set,
    output logic [KEY_BITS-1:0]                 item_key,
    output logic [VALUE_BITS-1:0]               item_value
);

    import lkv_pkg::*;

    localparam int IW = 1 + KEY_BITS + VALUE_BITS;

    logic [63:0]             key_ext, value_ext;
    logic [IW-1:0]           item_in, item_out;
    logic [$clog2(ITEM_Q_DEPTH+1)-1:0] item_count;
    logic                    unused_count;

    // take key and value to their stored widths, zero above the port width
    always_comb
    begin
        key_ext                      = '0;
        value_ext                    = '0;
        key_ext[KEY_PORT_BITS-1:0]   = lookup_key;
        value_ext[VALUE_PORT_BITS-1:0] = write_value;
        item_in = {(op == OP_SET), key_ext[KEY_BITS-1:0], value_ext[VALUE_BITS-1:0]};
    end

    lkv_fifo #(
        .WIDTH (IW),
        .DEPTH (ITEM_Q_DEPTH)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (item_in),
        .full  (full),
        .pop   (item_pop),
        .dout  (item_out),
        .empty (item_empty),
        .count (item_count)
    );

    assign unused_count = ^item_count;

    assign item_is_set = item_out[IW-1];
    assign item_key    = item_out[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
    assign item_value  = item_out[VALUE_BITS-1:0];

endmodule

// File: rtl/lkv_back.sv
// Back end: associative match, LRU rank update, key/valid store and value RAM.
// Depends on lkv_pkg and lkv_ram.
module lkv_back #(
    parameter int CAPACITY   = lkv_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_empty,
    input  logic                  item_is_set,
    input  logic [KEY_BITS-1:0]   item_key,
    input  logic [VALUE_BITS-1:0] item_value,
    output logic                  item_pop,
    input  logic                  res_room,
    output logic                  res_push,
    output lkv_pkg::res_t         res
);

    import lkv_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    back_state_t state_reg, state_next;

    // entry store
    logic [KEY_BITS-1:0] key_reg   [CAPACITY];
    logic [IW-1:0]       rank_reg  [CAPACITY];
    logic [IW-1:0]       rank_next [CAPACITY];
    logic [CAPACITY-1:0] valid_reg, valid_next;

    // item held between match and update
    logic                  set_q_reg;
    logic [KEY_BITS-1:0]   key_q_reg;
    logic [VALUE_BITS-1:0] value_q_reg;
    logic [CAPACITY-1:0]   match_reg, free_reg, victim_reg;
    logic [CAPACITY-1:0]   match_next, free_next, victim_next;

    // readback stage
    logic rb_valid_reg, rb_hit_reg, rb_get_hit_reg;

    logic                  start, exec;
    logic                  hit_w, any_free;
    logic                  was_valid;
    logic [CAPACITY-1:0]   tgt_oh;
    logic [IW-1:0]         tgt_idx, old_rank;
    logic                  ram_we, ram_re;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic [63:0]           rdata_ext;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_MATCH:
            begin
                if (!item_empty && res_room)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                state_next = BK_MATCH;
            end
            default:
            begin
                state_next = BK_MATCH;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        start = 1'b0;
        exec  = 1'b0;
        case (state_reg)
            BK_MATCH:
            begin
                start = !item_empty && res_room;
            end
            BK_EXEC:
            begin
                exec = 1'b1;
            end
            default:
            begin
                start = 1'b0;
            end
        endcase
    end

    assign item_pop = start;

    // match cycle: compare all keys, find lowest free entry and LRU victim
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_next[i]  = valid_reg[i] && (key_reg[i] == item_key);
            victim_next[i] = valid_reg[i] && (rank_reg[i] == IW'(CAPACITY-1));
        end
        free_next = ~valid_reg & (valid_reg + 1'b1);
    end

    // update cycle: choose target entry and work out promotion
    always_comb
    begin
        hit_w    = |match_reg;
        any_free = |free_reg;
        tgt_oh   = hit_w ? match_reg : (any_free ? free_reg : victim_reg);
        tgt_idx  = '0;
        old_rank = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (tgt_oh[i])
            begin
                tgt_idx  = tgt_idx | IW'(i);
                old_rank = old_rank | rank_reg[i];
            end
        end
        was_valid = hit_w || !any_free;
    end

    // rank and valid next values
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (exec && (hit_w || set_q_reg))
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (tgt_oh[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (!was_valid || (rank_reg[i] < old_rank)))
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
            if (set_q_reg)
            begin
                valid_next = valid_reg | tgt_oh;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_MATCH;
            valid_reg      <= '0;
            rb_valid_reg   <= 1'b0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            rb_valid_reg <= exec;
            for (int i = 0; i < CAPACITY; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // payload: held item, match vectors, stored keys, readback flags
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            set_q_reg   <= item_is_set;
            key_q_reg   <= item_key;
            value_q_reg <= item_value;
            match_reg   <= match_next;
            free_reg    <= free_next;
            victim_reg  <= victim_next;
        end
        if (exec && set_q_reg && !hit_w)
        begin
            key_reg[tgt_idx] <= key_q_reg;
        end
        if (exec)
        begin
            rb_hit_reg     <= hit_w;
            rb_get_hit_reg <= hit_w && !set_q_reg;
        end
    end

    // value store: write on every set, read on a get hit
    assign ram_we = exec && set_q_reg;
    assign ram_re = exec && hit_w && !set_q_reg;

    lkv_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tgt_idx),
        .wdata (value_q_reg),
        .re    (ram_re),
        .raddr (tgt_idx),
        .rdata (ram_rdata)
    );

    // result item, value cut to the port width
    always_comb
    begin
        rdata_ext                 = '0;
        rdata_ext[VALUE_BITS-1:0] = ram_rdata;
        res.hit                   = rb_hit_reg;
        res.read_value            = rb_get_hit_reg ? rdata_ext[VALUE_PORT_BITS-1:0] : '0;
    end

    assign res_push = rb_valid_reg;

endmodule

// File: rtl/lru_key_value_cache_top.sv
// Top level of the fully associative LRU key-value cache.
// Depends on lkv_pkg, lkv_front, lkv_back, lkv_fifo and lkv_ram.

// Fully associative key-value cache of CAPACITY entries with least-recently-used
// replacement. Push a get (op 0) or set (op 1) while full is low; one result per
// item comes out in order on the result queue (hit, read_value) while empty is low,
// taken with pop. The back end works on one item at a time, in a match cycle that
// compares the key against every stored entry and then an update cycle that rewrites the
// recency ranks and writes or reads the value RAM; it takes the next item only after
// that update and only while the result queue has room. Valid marks are cleared by
// reset at once, so the block takes items straight after reset.
module lru_key_value_cache_top #(
    parameter int CAPACITY   = lkv_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                op,
    input  logic [lkv_pkg::KEY_PORT_BITS-1:0]   lookup_key,
    input  logic [lkv_pkg::VALUE_PORT_BITS-1:0] write_value,
    output logic                                empty,
    input  logic                                pop,
    output logic                                hit,
    output logic [lkv_pkg::VALUE_PORT_BITS-1:0] read_value
);

    import lkv_pkg::*;

    localparam int RES_CNT_W = $clog2(RES_Q_DEPTH+1);

    logic                  item_pop, item_empty, item_is_set;
    logic [KEY_BITS-1:0]   item_key;
    logic [VALUE_BITS-1:0] item_value;
    logic                  res_push, res_full, res_room;
    res_t                  res_in, res_out;
    logic [RES_CNT_W-1:0]  res_count;

    lkv_front #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .lookup_key  (lookup_key),
        .write_value (write_value),
        .item_pop    (item_pop),
        .item_empty  (item_empty),
        .item_is_set (item_is_set),
        .item_key    (item_key),
        .item_value  (item_value)
    );

    // room for the item in flight plus the new one
    assign res_room = (res_count <= RES_CNT_W'(RES_Q_DEPTH-2));

    lkv_back #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_empty  (item_empty),
        .item_is_set (item_is_set),
        .item_key    (item_key),
        .item_value  (item_value),
        .item_pop    (item_pop),
        .res_room    (res_room),
        .res_push    (res_push),
        .res         (res_in)
    );

    lkv_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty),
        .count (res_count)
    );

    assign hit        = res_out.hit;
    assign read_value = res_out.read_value;

    // result queue credit must never let a result be dropped
    a_res_no_overflow: assert property (
        @(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result pushed into a full result queue");

    // the back end only takes an item that is there
    a_item_pop_valid: assert property (
        @(posedge clk) disable iff (!rst_n) item_pop |-> !item_empty)
        else $error("item taken from an empty item queue");

    // a taken item yields a result, pushed after the update state and the readback register
    a_item_to_result: assert property (
        @(posedge clk) disable iff (!rst_n) item_pop |=> ##1 res_push)
        else $error("accepted item produced no result");

    // a miss never returns data
    a_miss_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_push && !res_in.hit) |-> (res_in.read_value == '0))
        else $error("miss result carries a non-zero value");

endmodule
